// ===== hdl/ugpl_pkg.sv =====
`timescale 1ns / 1ps

package ugpl_pkg;

    localparam int MAX_CELLS_PER_AXIS = 1024;
    localparam int COORD_FRAC_BITS    = 16;
    localparam int INV_FRAC_BITS      = 16;

    localparam int COORD_W    = 32;
    localparam int INV_W      = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = COORD_W + INV_W;
    localparam int PROD_SHIFT = COORD_FRAC_BITS + INV_FRAC_BITS;
    localparam int FLOOR_W    = PROD_W - PROD_SHIFT;
    localparam int FIELD_W    = 12;
    localparam int COUNT_W    = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int IDX_W      = $clog2(MAX_CELLS_PER_AXIS);
    localparam int AREA_W     = 2 * COUNT_W;
    localparam int ROW_W      = IDX_W + COUNT_W;
    localparam int SLAB_W     = IDX_W + AREA_W;
    localparam int SUM_W      = SLAB_W + 1;
    localparam int INDEX_W    = 30;
    localparam int COUNTS_W   = 3 * FIELD_W;
    localparam int DIM_W      = 2;
    localparam int CFG_DATA_W = COUNTS_W;

    // register stages inside one axis unit
    localparam int AXIS_STAGES = 4;

    typedef enum logic [2:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_ORIGIN_Z      = 3'd2,
        REG_INV_SPACING_X = 3'd3,
        REG_INV_SPACING_Y = 3'd4,
        REG_INV_SPACING_Z = 3'd5,
        REG_CELL_COUNTS   = 3'd6,
        REG_DIMENSION     = 3'd7
    } cfg_reg_t;

    localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
    localparam logic [DIM_W-1:0] DIM_3D = 2'd3;

    localparam logic [INV_W-1:0]    INV_SPACING_RESET = 32'd65536;
    localparam logic [COUNTS_W-1:0] CELL_COUNTS_RESET = 36'd16781313;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } axis_res_t;

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [FIELD_W-1:0] field);
        logic [COUNT_W-1:0] result;
        if (int'(field) > MAX_CELLS_PER_AXIS)
        begin
            result = COUNT_W'(MAX_CELLS_PER_AXIS);
        end
        else
        begin
            result = COUNT_W'(field);
        end
        return result;
    endfunction

endpackage

// ===== hdl/ugpl_point_if.sv =====
`timescale 1ns / 1ps

interface ugpl_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [ugpl_pkg::COORD_W-1:0] coord_x;
    logic signed [ugpl_pkg::COORD_W-1:0] coord_y;
    logic signed [ugpl_pkg::COORD_W-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

// ===== hdl/ugpl_result_if.sv =====
`timescale 1ns / 1ps

interface ugpl_result_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [ugpl_pkg::INDEX_W-1:0]  cell_index;

    modport source (output valid, output found, output cell_index, input ready);
    modport sink   (input valid, input found, input cell_index, output ready);
endinterface

// ===== hdl/ugpl_axis.sv =====
`timescale 1ns / 1ps

module ugpl_axis (
    input  logic                                clk,
    input  logic                                advance,
    input  logic signed [ugpl_pkg::COORD_W-1:0] coord,
    input  logic signed [ugpl_pkg::COORD_W-1:0] origin,
    input  logic [ugpl_pkg::INV_W-1:0]          inv_spacing,
    input  logic [ugpl_pkg::COUNT_W-1:0]        count,
    output ugpl_pkg::axis_res_t                 res
);
    import ugpl_pkg::*;

    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DIFF_W-1:0]  diff_next;
    logic [COORD_W-1:0]        mag_reg;
    logic [COORD_W-1:0]        mag_next;
    logic                      neg_s2_reg;
    logic                      neg_s3_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         prod_next;
    axis_res_t                 res_reg;
    axis_res_t                 res_next;

    logic [FLOOR_W-1:0]        fl;
    logic [PROD_SHIFT-1:0]     fr;
    logic [FLOOR_W-1:0]        cnt_ext;
    logic                      on_face;
    logic                      in_range;

    assign diff_next = DIFF_W'(coord) - DIFF_W'(origin);

    always_comb
    begin
        if (diff_reg[DIFF_W-1])
        begin
            mag_next = COORD_W'(-diff_reg);
        end
        else
        begin
            mag_next = COORD_W'(diff_reg);
        end
    end

    assign prod_next = PROD_W'(mag_reg) * PROD_W'(inv_spacing);

    assign fl       = prod_reg[PROD_W-1:PROD_SHIFT];
    assign fr       = prod_reg[PROD_SHIFT-1:0];
    assign cnt_ext  = FLOOR_W'(count);
    assign on_face  = (fl == cnt_ext);
    assign in_range = (fl < cnt_ext) || (on_face && (fr == '0));

    always_comb
    begin
        res_next.hit = (count != '0) && (!neg_s3_reg || (prod_reg == '0)) && in_range;
        if (on_face)
        begin
            res_next.idx = IDX_W'(count - COUNT_W'(1));
        end
        else
        begin
            res_next.idx = IDX_W'(fl);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff_reg   <= diff_next;
            mag_reg    <= mag_next;
            neg_s2_reg <= diff_reg[DIFF_W-1];
            prod_reg   <= prod_next;
            neg_s3_reg <= neg_s2_reg;
            res_reg    <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== hdl/uniform_grid_point_locator_core.sv =====
// uniform grid point locator: one point in, one cell location out
// path: the axis unit register stages, then the combine registers, then the output register
// throughput: one point per cycle; the whole pipeline holds while location is stalled
// reset: rst_n clears all valid bits and loads the register defaults
//   (origin 0, inverse spacing 1.0, one cell per axis, 3d mode)
`timescale 1ns / 1ps

module uniform_grid_point_locator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  ugpl_pkg::cfg_reg_t                  cfg_index,
    input  logic [ugpl_pkg::CFG_DATA_W-1:0]     cfg_data,
    ugpl_point_if.sink                          point,
    ugpl_result_if.source                       location
);
    import ugpl_pkg::*;

    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic signed [COORD_W-1:0] origin_z_reg;
    logic [INV_W-1:0]          inv_x_reg;
    logic [INV_W-1:0]          inv_y_reg;
    logic [INV_W-1:0]          inv_z_reg;
    logic [COUNTS_W-1:0]       counts_reg;
    logic [DIM_W-1:0]          dim_reg;

    logic [COUNT_W-1:0]        cnt_x;
    logic [COUNT_W-1:0]        cnt_y;
    logic [COUNT_W-1:0]        cnt_z;
    logic [AREA_W-1:0]         area_reg;
    logic [AREA_W-1:0]         area_next;

    logic                      advance;
    logic [AXIS_STAGES-1:0]    valid_reg;
    axis_res_t                 res_x;
    axis_res_t                 res_y;
    axis_res_t                 res_z;

    logic                      dim_ok;
    logic                      is_3d;
    logic                      ok_next;
    logic                      ok_reg;
    logic                      s5_valid_reg;
    logic [IDX_W-1:0]          ix_reg;
    logic [IDX_W-1:0]          iz;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;
    logic [SLAB_W-1:0]         slab_reg;
    logic [SLAB_W-1:0]         slab_next;
    logic [SUM_W-1:0]          sum;

    logic                      out_valid_reg;
    logic                      found_reg;
    logic [INDEX_W-1:0]        index_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_x_reg    <= INV_SPACING_RESET;
            inv_y_reg    <= INV_SPACING_RESET;
            inv_z_reg    <= INV_SPACING_RESET;
            counts_reg   <= CELL_COUNTS_RESET;
            dim_reg      <= DIM_3D;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:      origin_x_reg <= COORD_W'(cfg_data);
                REG_ORIGIN_Y:      origin_y_reg <= COORD_W'(cfg_data);
                REG_ORIGIN_Z:      origin_z_reg <= COORD_W'(cfg_data);
                REG_INV_SPACING_X: inv_x_reg    <= INV_W'(cfg_data);
                REG_INV_SPACING_Y: inv_y_reg    <= INV_W'(cfg_data);
                REG_INV_SPACING_Z: inv_z_reg    <= INV_W'(cfg_data);
                REG_CELL_COUNTS:   counts_reg   <= COUNTS_W'(cfg_data);
                REG_DIMENSION:     dim_reg      <= DIM_W'(cfg_data);
                default:           dim_reg      <= dim_reg;
            endcase
        end
    end

    assign cnt_x     = clamp_count(counts_reg[FIELD_W-1:0]);
    assign cnt_y     = clamp_count(counts_reg[2*FIELD_W-1:FIELD_W]);
    assign cnt_z     = clamp_count(counts_reg[3*FIELD_W-1:2*FIELD_W]);
    assign area_next = AREA_W'(cnt_x) * AREA_W'(cnt_y);

    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
    end

    // whole pipeline moves when the output register is free
    assign advance     = !out_valid_reg || location.ready;
    assign point.ready = advance;

    ugpl_axis u_axis_x (
        .clk         (clk),
        .advance     (advance),
        .coord       (point.coord_x),
        .origin      (origin_x_reg),
        .inv_spacing (inv_x_reg),
        .count       (cnt_x),
        .res         (res_x)
    );

    ugpl_axis u_axis_y (
        .clk         (clk),
        .advance     (advance),
        .coord       (point.coord_y),
        .origin      (origin_y_reg),
        .inv_spacing (inv_y_reg),
        .count       (cnt_y),
        .res         (res_y)
    );

    ugpl_axis u_axis_z (
        .clk         (clk),
        .advance     (advance),
        .coord       (point.coord_z),
        .origin      (origin_z_reg),
        .inv_spacing (inv_z_reg),
        .count       (cnt_z),
        .res         (res_z)
    );

    // combine axes and form the partial index products
    assign is_3d     = (dim_reg == DIM_3D);
    assign dim_ok    = (dim_reg == DIM_2D) || is_3d;
    assign ok_next   = dim_ok && res_x.hit && res_y.hit && (!is_3d || res_z.hit);
    assign iz        = is_3d ? res_z.idx : '0;
    assign row_next  = ROW_W'(res_y.idx) * ROW_W'(cnt_x);
    assign slab_next = SLAB_W'(iz) * SLAB_W'(area_reg);

    // final sum
    assign sum = SUM_W'(ix_reg) + SUM_W'(row_reg) + SUM_W'(slab_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[AXIS_STAGES-2:0], point.valid};
            s5_valid_reg  <= valid_reg[AXIS_STAGES-1];
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok_reg    <= ok_next;
            ix_reg    <= res_x.idx;
            row_reg   <= row_next;
            slab_reg  <= slab_next;
            found_reg <= ok_reg;
            index_reg <= ok_reg ? INDEX_W'(sum) : '0;
        end
    end

    assign location.valid      = out_valid_reg;
    assign location.found      = found_reg;
    assign location.cell_index = index_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ugpl_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int LATENCY        = 6;
    localparam int RANDOM_POINTS  = 1350;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int IDLE_PERCENT   = 7;

    localparam logic [COORD_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    // dimension codes the block rejects
    localparam logic [DIM_W-1:0] DIM_NONE = 2'd0;
    localparam logic [DIM_W-1:0] DIM_1D   = 2'd1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } location_t;

    typedef enum logic {
        ROW_POINT,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              reg_sel;
        logic [CFG_DATA_W-1:0] reg_value;
        point_t                pt;
        logic                  typed;
        location_t             known;
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ugpl_point_if  point_ch();
    ugpl_result_if loc_ch();

    uniform_grid_point_locator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point     (point_ch.sink),
        .location  (loc_ch.source)
    );

    // register copies used by the predictor
    logic [COORD_W-1:0]  origin_q [3];
    logic [INV_W-1:0]    inv_q [3];
    logic [COUNTS_W-1:0] counts_q;
    logic [DIM_W-1:0]    dim_q;

    location_t pending_locations[$];
    step_row_t directed_rows[$];

    int        points_sent;
    int        located_count;
    int        outside_count;
    int        fault_count;
    int        setting_count;
    int        stall_cycles;
    location_t got_loc;
    location_t want_loc;
    logic      calm;

    assign calm = (points_sent >= 400) && (points_sent < 750);

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [63:0] axis_cell_count(input int axis);
        logic [63:0] cnt;
        cnt = 64'(counts_q[axis*FIELD_W +: FIELD_W]);
        if (cnt > MAX_CELLS_PER_AXIS)
        begin
            cnt = 64'(MAX_CELLS_PER_AXIS);
        end
        return cnt;
    endfunction

    function automatic logic axis_cell(input logic [COORD_W-1:0] coord,
                                       input logic [COORD_W-1:0] org,
                                       input logic [INV_W-1:0] inv,
                                       input logic [63:0] count,
                                       output logic [63:0] axis_idx);
        logic [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0] mag;
        logic [PROD_W:0]   prod;
        logic [DIFF_W-1:0] whole;
        axis_idx = '0;
        diff = {coord[COORD_W-1], coord} - {org[COORD_W-1], org};
        mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        prod = mag * inv;
        if (count == 0)
        begin
            return 1'b0;
        end
        if (diff[DIFF_W-1] && prod != 0)
        begin
            return 1'b0;
        end
        whole = prod[PROD_W:PROD_SHIFT];
        if (whole > count || (whole == count && prod[PROD_SHIFT-1:0] != 0))
        begin
            return 1'b0;
        end
        axis_idx = (whole == count) ? count - 1 : 64'(whole);
        return 1'b1;
    endfunction

    function automatic location_t locate_point(input point_t p);
        location_t   res;
        logic        ok;
        logic [63:0] cx;
        logic [63:0] cy;
        logic [63:0] ix;
        logic [63:0] iy;
        logic [63:0] iz;
        logic [63:0] lin;
        cx = axis_cell_count(0);
        cy = axis_cell_count(1);
        ix = '0;
        iy = '0;
        iz = '0;
        ok = 1'b0;
        if (dim_q == DIM_2D || dim_q == DIM_3D)
        begin
            ok = axis_cell(p.x, origin_q[0], inv_q[0], cx, ix);
            if (ok)
            begin
                ok = axis_cell(p.y, origin_q[1], inv_q[1], cy, iy);
            end
            if (ok && dim_q == DIM_3D)
            begin
                ok = axis_cell(p.z, origin_q[2], inv_q[2], axis_cell_count(2), iz);
            end
        end
        if (dim_q != DIM_3D)
        begin
            iz = '0;
        end
        lin = ix + iy * cx + iz * cx * cy;
        res.found = ok;
        res.index = ok ? lin[INDEX_W-1:0] : '0;
        return res;
    endfunction

    // coordinate aimed at the grid span of one axis, with some fully random ones
    function automatic logic [COORD_W-1:0] pick_coord(input int axis);
        longint           span;
        longint           offset;
        longint           c;
        logic [63:0]      cnt;
        logic [63:0]      r;
        int               m;
        cnt = axis_cell_count(axis);
        m = $urandom_range(0, 99);
        if (inv_q[axis] == 0 || m < 15)
        begin
            return $urandom;
        end
        span = longint'((cnt << 32) / 64'(inv_q[axis]));
        if (span > 64'sh2_0000_0000)
        begin
            span = 64'sh2_0000_0000;
        end
        r = {$urandom, $urandom};
        if (m < 30)
        begin
            offset = span + longint'($urandom_range(0, 8)) - 4;
        end
        else if (m < 38)
        begin
            offset = -longint'($urandom_range(0, 4));
        end
        else if (m < 50 && cnt != 0)
        begin
            offset = longint'(r % (cnt + 1)) * span / longint'(cnt);
        end
        else
        begin
            offset = longint'(r % 64'(span + span / 8 + 1)) - span / 16;
        end
        c = longint'($signed(origin_q[axis])) + offset;
        if (c > 64'sh7FFF_FFFF)
        begin
            c = 64'sh7FFF_FFFF;
        end
        if (c < -64'sh8000_0000)
        begin
            c = -64'sh8000_0000;
        end
        return c[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] rand_origin();
        int m;
        m = $urandom_range(0, 99);
        if (m < 8)
        begin
            return COORD_MIN;
        end
        if (m < 16)
        begin
            return COORD_MAX;
        end
        if (m < 40)
        begin
            return $urandom;
        end
        return $signed($urandom) >>> $urandom_range(8, 24);
    endfunction

    function automatic logic [INV_W-1:0] rand_inv();
        int m;
        m = $urandom_range(0, 99);
        if (m < 5)
        begin
            return '0;
        end
        if (m < 10)
        begin
            return '1;
        end
        if (m < 25)
        begin
            return $urandom;
        end
        if (m < 60)
        begin
            return INV_SPACING_RESET >> $urandom_range(0, 16);
        end
        return INV_SPACING_RESET << $urandom_range(0, 15);
    endfunction

    task automatic add_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic typed,
                             input logic found, input logic [INDEX_W-1:0] index);
        step_row_t row;
        row = '0;
        row.kind = ROW_POINT;
        row.pt = '{x: x, y: y, z: z};
        row.typed = typed;
        row.known = '{found: found, index: index};
        directed_rows.push_back(row);
    endtask

    task automatic add_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        step_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.reg_sel = sel;
        row.reg_value = value;
        directed_rows.push_back(row);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(posedge clk);
        case (sel)
            REG_ORIGIN_X:      origin_q[0] = value[COORD_W-1:0];
            REG_ORIGIN_Y:      origin_q[1] = value[COORD_W-1:0];
            REG_ORIGIN_Z:      origin_q[2] = value[COORD_W-1:0];
            REG_INV_SPACING_X: inv_q[0] = value[INV_W-1:0];
            REG_INV_SPACING_Y: inv_q[1] = value[INV_W-1:0];
            REG_INV_SPACING_Z: inv_q[2] = value[INV_W-1:0];
            REG_CELL_COUNTS:   counts_q = value[COUNTS_W-1:0];
            REG_DIMENSION:     dim_q = value[DIM_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic send_point(input point_t p, input location_t want);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.coord_x <= p.x;
        point_ch.coord_y <= p.y;
        point_ch.coord_z <= p.z;
        @(posedge clk);
        while (!point_ch.ready)
        begin
            @(posedge clk);
        end
        pending_locations.push_back(want);
        points_sent++;
    endtask

    task automatic finish_pending();
        point_ch.valid <= 1'b0;
        while (pending_locations.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic report_fault(input string what, input location_t want, input location_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected found=%0b index=%0d, got found=%0b index=%0d",
                     $time, what, want.found, want.index, got.found, got.index);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && loc_ch.valid && loc_ch.ready)
        begin
            got_loc = '{found: loc_ch.found, index: loc_ch.cell_index};
            if (got_loc.found === 1'b1)
            begin
                located_count++;
            end
            else
            begin
                outside_count++;
            end
            if (pending_locations.size() == 0)
            begin
                report_fault("location with no request waiting", '0, got_loc);
            end
            else
            begin
                want_loc = pending_locations.pop_front();
                if (got_loc !== want_loc)
                begin
                    report_fault("location mismatch", want_loc, got_loc);
                end
            end
        end
        loc_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if ((point_ch.valid && point_ch.ready) || (loc_ch.valid && loc_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        step_row_t   row;
        location_t   want;
        point_t      p;
        logic        last_was_write;
        int          remaining;
        int          batch;
        logic [COUNTS_W-1:0] counts;
        int          m;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        point_ch.valid = 1'b0;
        point_ch.coord_x = '0;
        point_ch.coord_y = '0;
        point_ch.coord_z = '0;
        loc_ch.ready = 1'b0;
        points_sent = 0;
        located_count = 0;
        outside_count = 0;
        fault_count = 0;
        setting_count = 1;
        stall_cycles = 0;
        for (int a = 0; a < 3; a++)
        begin
            origin_q[a] = '0;
            inv_q[a] = INV_SPACING_RESET;
        end
        counts_q = CELL_COUNTS_RESET;
        dim_q = DIM_3D;

        // reset grid: one unit cell per axis at the origin
        add_point('0, '0, '0, 1'b1, 1'b1, '0);
        add_point(Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b1, '0);
        add_point(Q_ONE + 1, '0, '0, 1'b1, 1'b0, '0);
        add_point('1, '0, '0, 1'b1, 1'b0, '0);
        add_point('0, Q_ONE + 1, '0, 1'b1, 1'b0, '0);
        add_point('0, '0, COORD_MAX, 1'b1, 1'b0, '0);
        add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0, '0);
        add_point(Q_ONE >> 1, Q_ONE >> 1, Q_ONE >> 1, 1'b1, 1'b1, '0);
        // 2d ignores z
        add_write(REG_DIMENSION, CFG_DATA_W'(DIM_2D));
        add_point(Q_ONE >> 1, '0, COORD_MIN, 1'b0, 1'b0, '0);
        // zero inverse spacing
        add_write(REG_INV_SPACING_X, '0);
        add_point(COORD_MAX, '0, '0, 1'b0, 1'b0, '0);
        add_point(COORD_MIN, '0, '0, 1'b0, 1'b0, '0);
        // widest difference with the largest inverse spacing
        add_write(REG_INV_SPACING_X, CFG_DATA_W'(32'hFFFF_FFFF));
        add_write(REG_ORIGIN_X, CFG_DATA_W'(COORD_MIN));
        add_point(COORD_MAX, '0, '0, 1'b0, 1'b0, '0);
        add_point(COORD_MIN, '0, '0, 1'b0, 1'b0, '0);
        // counts above the limit, index spanning all 30 bits
        add_write(REG_ORIGIN_X, '0);
        add_write(REG_INV_SPACING_X, CFG_DATA_W'(INV_SPACING_RESET));
        add_write(REG_CELL_COUNTS, '1);
        add_write(REG_DIMENSION, CFG_DATA_W'(DIM_3D));
        add_point(32'h03FF_8000, 32'h03FF_8000, 32'h03FF_8000, 1'b0, 1'b0, '0);
        add_point(32'h0400_0000, 32'h0400_0000, 32'h0400_0000, 1'b0, 1'b0, '0);
        add_point(32'h0400_0001, 32'h0400_0000, 32'h0400_0000, 1'b0, 1'b0, '0);
        // zero counts
        add_write(REG_CELL_COUNTS, 36'h001_000_001);
        add_point('0, '0, '0, 1'b0, 1'b0, '0);
        add_write(REG_CELL_COUNTS, 36'h000_001_001);
        add_point('0, '0, '0, 1'b0, 1'b0, '0);
        add_write(REG_DIMENSION, CFG_DATA_W'(DIM_2D));
        add_point('0, '0, Q_ONE * 5, 1'b0, 1'b0, '0);
        // unsupported dimensions
        add_write(REG_DIMENSION, CFG_DATA_W'(DIM_NONE));
        add_point('0, '0, '0, 1'b0, 1'b0, '0);
        add_write(REG_DIMENSION, CFG_DATA_W'(DIM_1D));
        add_point('0, '0, '0, 1'b0, 1'b0, '0);
        // origin extremes on y and z
        add_write(REG_ORIGIN_Y, CFG_DATA_W'(COORD_MAX));
        add_write(REG_ORIGIN_Z, CFG_DATA_W'(COORD_MIN));
        add_write(REG_INV_SPACING_Y, CFG_DATA_W'(32'hFFFF_FFFF));
        add_write(REG_INV_SPACING_Z, '0);
        add_write(REG_CELL_COUNTS, 36'h004_004_004);
        add_write(REG_DIMENSION, CFG_DATA_W'(DIM_3D));
        add_point('0, COORD_MAX, COORD_MAX, 1'b0, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        last_was_write = 1'b0;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                if (!last_was_write)
                begin
                    finish_pending();
                    setting_count++;
                end
                write_reg(row.reg_sel, row.reg_value);
                last_was_write = 1'b1;
            end
            else
            begin
                if (last_was_write)
                begin
                    cfg_write <= 1'b0;
                end
                last_was_write = 1'b0;
                want = row.typed ? row.known : locate_point(row.pt);
                send_point(row.pt, want);
            end
        end

        remaining = RANDOM_POINTS;
        while (remaining > 0)
        begin
            finish_pending();
            write_reg(REG_ORIGIN_X, CFG_DATA_W'(rand_origin()));
            write_reg(REG_ORIGIN_Y, CFG_DATA_W'(rand_origin()));
            write_reg(REG_ORIGIN_Z, CFG_DATA_W'(rand_origin()));
            write_reg(REG_INV_SPACING_X, CFG_DATA_W'(rand_inv()));
            write_reg(REG_INV_SPACING_Y, CFG_DATA_W'(rand_inv()));
            write_reg(REG_INV_SPACING_Z, CFG_DATA_W'(rand_inv()));
            for (int a = 0; a < 3; a++)
            begin
                m = $urandom_range(0, 99);
                if (m < 8)
                begin
                    counts[a*FIELD_W +: FIELD_W] = '0;
                end
                else if (m < 16)
                begin
                    counts[a*FIELD_W +: FIELD_W] = '1;
                end
                else if (m < 21)
                begin
                    counts[a*FIELD_W +: FIELD_W] = FIELD_W'(MAX_CELLS_PER_AXIS);
                end
                else if (m < 25)
                begin
                    counts[a*FIELD_W +: FIELD_W] = FIELD_W'(MAX_CELLS_PER_AXIS + 1);
                end
                else
                begin
                    counts[a*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(1, 16));
                end
            end
            write_reg(REG_CELL_COUNTS, counts);
            m = $urandom_range(0, 99);
            write_reg(REG_DIMENSION, CFG_DATA_W'((m < 4) ? DIM_NONE :
                                                 (m < 8) ? DIM_1D :
                                                 (m < 25) ? DIM_2D : DIM_3D));
            cfg_write <= 1'b0;
            setting_count++;
            batch = $urandom_range(20, 80);
            if (batch > remaining)
            begin
                batch = remaining;
            end
            for (int k = 0; k < batch; k++)
            begin
                p.x = pick_coord(0);
                p.y = pick_coord(1);
                p.z = pick_coord(2);
                send_point(p, locate_point(p));
            end
            remaining -= batch;
        end

        finish_pending();
        repeat (LATENCY + 4) @(posedge clk);
        if (pending_locations.size() != 0)
        begin
            fault_count += pending_locations.size();
            $display("%0d locations never arrived", pending_locations.size());
        end

        $display("%0d points over %0d register settings: %0d located in the grid, %0d outside",
                 points_sent, setting_count, located_count, outside_count);
        $display("%0d faults", fault_count);
        if (fault_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
